// ----- src/bgwf_pkg.sv -----
`timescale 1ns / 1ps
// bgwf_pkg: shared types and constants of the background/window tile fetcher.
// No dependencies; used by every module under src.

package bgwf_pkg;

  // Input beat function codes
  localparam logic [1:0] FUNC_LINE_START = 2'd0;
  localparam logic [1:0] FUNC_TICK       = 2'd1;
  localparam logic [1:0] FUNC_DATA       = 2'd2;
  localparam logic [1:0] FUNC_TAKE       = 2'd3;

  // Line modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_BG     = 2'd1;
  localparam logic [1:0] MODE_WIN    = 2'd2;
  localparam logic [1:0] MODE_BG_WIN = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_LCD_CONTROL = 3'd0;
  localparam logic [2:0] CFG_WINDOW_X    = 3'd1;
  localparam logic [2:0] CFG_WINDOW_Y    = 3'd2;
  localparam logic [2:0] CFG_SCROLL_X    = 3'd3;
  localparam logic [2:0] CFG_SCROLL_Y    = 3'd4;
  localparam logic [2:0] CFG_BG_PALETTE  = 3'd5;

  // Memory map
  localparam logic [15:0] MAP_LOW_BASE    = 16'h9800;
  localparam logic [15:0] MAP_HIGH_BASE   = 16'h9c00;
  localparam logic [15:0] TILE_DATA_BASE  = 16'h8000;
  localparam logic [15:0] SIGNED_BIAS     = 16'h1000;
  localparam logic [15:0] OFF_ADDR        = 16'hffff;

  // Window placement limits
  localparam logic [7:0] WX_MAX      = 8'd166;
  localparam logic [7:0] WY_MAX      = 8'd143;
  localparam logic [7:0] WX_ALIGNED  = 8'd7;
  localparam logic [7:0] SWAP_NEVER  = 8'd255;
  localparam logic [7:0] PUSH_LIMIT  = 8'd247;
  localparam logic [3:0] FULL_OFFSET = 4'd8;

  // Fetch sequencer phases
  typedef enum logic [3:0] {
    PH_ID   = 4'b0001,
    PH_LOW  = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_IDLE = 4'b1000
  } phase_t;

  // Per-line geometry latched at line start
  typedef struct packed {
    logic [1:0]  mode;
    logic        signed_data;
    logic [15:0] bg_base;
    logic [15:0] win_base;
    logic [2:0]  bg_row;
    logic [2:0]  win_row;
    logic [4:0]  tile_col;
    logic [7:0]  swap_point;
    logic [3:0]  win_offset;
  } setup_t;

  // One result beat
  typedef struct packed {
    logic        read_req;
    logic [15:0] read_addr;
    logic        tile_staged;
    logic        pixels_valid;
    logic [15:0] pixel_colors;
    logic [7:0]  pixel_palette;
    logic [3:0]  fine_offset;
    logic [1:0]  line_mode;
  } result_t;

endpackage

// ----- src/bg_window_tile_fetcher_unit.sv -----
`timescale 1ns / 1ps
// bg_window_tile_fetcher_unit: top level of the background/window tile fetcher.
// Depends on bgwf_pkg, bgwf_line_setup and bgwf_out_buf.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | func, line_number, mem_data
//  out_    | output    | out_valid/out_stall| read_req ... line_mode
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each input beat updates fetch state at the accepting edge, and its result beat is
// registered in the same edge, so one beat per clock is sustained while in_stall is low.
// The result is registered into the output entry, or into the skid entry under stall, and driven on out_.
// A two-entry result buffer absorbs a stall; in_stall rises only when both are held.
// Synchronous active-low reset clears configuration and all fetch state.

module bg_window_tile_fetcher_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_line_number,
  input  logic [7:0]  in_mem_data,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_read_req,
  output logic [15:0] out_read_addr,
  output logic        out_tile_staged,
  output logic        out_pixels_valid,
  output logic [15:0] out_pixel_colors,
  output logic [7:0]  out_pixel_palette,
  output logic [3:0]  out_fine_offset,
  output logic [1:0]  out_line_mode,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Configuration registers
  logic [7:0] lcd_control_r, window_x_r, window_y_r, scroll_x_r, scroll_y_r, bg_palette_r;

  // Fetch state
  bgwf_pkg::phase_t phase_r, phase_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [1:0]  hrc_r, hrc_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        signed_r, signed_nxt;
  logic [15:0] bg_base_r, bg_base_nxt;
  logic [15:0] win_base_r, win_base_nxt;
  logic [2:0]  bg_row_r, bg_row_nxt;
  logic [2:0]  win_row_r, win_row_nxt;
  logic [4:0]  col_r, col_nxt;
  logic [7:0]  pushed_r, pushed_nxt;
  logic [7:0]  swap_r, swap_nxt;
  logic        swapped_r, swapped_nxt;
  logic        idle_done_r, idle_done_nxt;
  logic [7:0]  tile_id_r, tile_id_nxt;
  logic [15:0] data_addr_r, data_addr_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  high_r, high_nxt;
  logic        full_r, full_nxt;
  logic [3:0]  win_off_r, win_off_nxt;
  logic [7:0]  pal_r, pal_nxt;

  logic              accept;
  logic              buf_full;
  bgwf_pkg::setup_t  setup;
  bgwf_pkg::result_t res;
  bgwf_pkg::result_t out_beat;

  // Sequencer helpers
  logic [1:0]  hrc_inc;
  logic [15:0] id_base;
  logic [15:0] tile_addr;
  logic [15:0] tile_addr_biased;
  logic [2:0]  row_sel;
  logic [15:0] low_addr;
  logic [15:0] pix;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !buf_full;

  bgwf_line_setup u_setup (
    .lcd_control (lcd_control_r),
    .window_x    (window_x_r),
    .window_y    (window_y_r),
    .scroll_x    (scroll_x_r),
    .scroll_y    (scroll_y_r),
    .line_number (in_line_number),
    .setup       (setup)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_control_r <= '0;
      window_x_r    <= '0;
      window_y_r    <= '0;
      scroll_x_r    <= '0;
      scroll_y_r    <= '0;
      bg_palette_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bgwf_pkg::CFG_LCD_CONTROL: lcd_control_r <= cfg_data;
        bgwf_pkg::CFG_WINDOW_X:    window_x_r    <= cfg_data;
        bgwf_pkg::CFG_WINDOW_Y:    window_y_r    <= cfg_data;
        bgwf_pkg::CFG_SCROLL_X:    scroll_x_r    <= cfg_data;
        bgwf_pkg::CFG_SCROLL_Y:    scroll_y_r    <= cfg_data;
        bgwf_pkg::CFG_BG_PALETTE:  bg_palette_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address terms
  assign hrc_inc          = (hrc_r < 2'd2) ? hrc_r + 2'd1 : hrc_r;
  assign tile_addr        = bgwf_pkg::TILE_DATA_BASE + {4'd0, tile_id_r, 4'd0};
  assign tile_addr_biased = (signed_r && !tile_id_r[7]) ? tile_addr + bgwf_pkg::SIGNED_BIAS
                                                        : tile_addr;
  assign row_sel          = (mode_r == bgwf_pkg::MODE_WIN ||
                             (mode_r == bgwf_pkg::MODE_BG_WIN && swapped_r)) ? win_row_r
                                                                             : bg_row_r;
  assign low_addr         = (mode_r == bgwf_pkg::MODE_OFF) ? bgwf_pkg::OFF_ADDR
                          : tile_addr_biased + {12'd0, row_sel, 1'b0};

  // Pixel interleave: pixel i from bit i of each plane
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pix[2*i]   = low_r[i];
      pix[2*i+1] = high_r[i];
    end
  end

  // Next fetch state and result beat
  always_comb begin
    phase_nxt     = phase_r;
    awaiting_nxt  = awaiting_r;
    hrc_nxt       = hrc_r;
    mode_nxt      = mode_r;
    signed_nxt    = signed_r;
    bg_base_nxt   = bg_base_r;
    win_base_nxt  = win_base_r;
    bg_row_nxt    = bg_row_r;
    win_row_nxt   = win_row_r;
    col_nxt       = col_r;
    pushed_nxt    = pushed_r;
    swap_nxt      = swap_r;
    swapped_nxt   = swapped_r;
    idle_done_nxt = idle_done_r;
    tile_id_nxt   = tile_id_r;
    data_addr_nxt = data_addr_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    full_nxt      = full_r;
    win_off_nxt   = win_off_r;
    pal_nxt       = pal_r;
    id_base       = bg_base_r;
    res           = '0;

    unique case (in_func)
      bgwf_pkg::FUNC_LINE_START: begin
        phase_nxt     = bgwf_pkg::PH_ID;
        awaiting_nxt  = 1'b0;
        hrc_nxt       = '0;
        mode_nxt      = setup.mode;
        signed_nxt    = setup.signed_data;
        bg_base_nxt   = setup.bg_base;
        win_base_nxt  = setup.win_base;
        bg_row_nxt    = setup.bg_row;
        win_row_nxt   = setup.win_row;
        col_nxt       = setup.tile_col;
        pushed_nxt    = '0;
        swap_nxt      = setup.swap_point;
        swapped_nxt   = 1'b0;
        idle_done_nxt = 1'b0;
        tile_id_nxt   = '0;
        data_addr_nxt = '0;
        low_nxt       = '0;
        high_nxt      = '0;
        full_nxt      = 1'b0;
        win_off_nxt   = setup.win_offset;
        pal_nxt       = bg_palette_r;
      end
      bgwf_pkg::FUNC_TICK: begin
        if (!awaiting_r) begin
          hrc_nxt = hrc_inc;
          if (hrc_inc == 2'd2 || phase_r == bgwf_pkg::PH_IDLE) begin
            hrc_nxt = '0;
            unique case (phase_r)
              bgwf_pkg::PH_ID: begin
                priority if (mode_r == bgwf_pkg::MODE_OFF) begin
                  id_base = bgwf_pkg::OFF_ADDR;
                end else if (mode_r == bgwf_pkg::MODE_BG) begin
                  id_base = bg_base_r;
                end else if (mode_r == bgwf_pkg::MODE_WIN) begin
                  id_base = win_base_r;
                end else if (pushed_r >= swap_r) begin
                  id_base     = win_base_r;
                  swapped_nxt = 1'b1;
                end else begin
                  id_base = bg_base_r;
                end
                res.read_req  = 1'b1;
                res.read_addr = id_base + {11'd0, col_r};
                phase_nxt     = bgwf_pkg::PH_LOW;
                awaiting_nxt  = 1'b1;
              end
              bgwf_pkg::PH_LOW: begin
                data_addr_nxt = low_addr;
                res.read_req  = 1'b1;
                res.read_addr = low_addr;
                phase_nxt     = bgwf_pkg::PH_HIGH;
                awaiting_nxt  = 1'b1;
              end
              bgwf_pkg::PH_HIGH: begin
                res.read_req  = 1'b1;
                res.read_addr = data_addr_r + 16'd1;
                phase_nxt     = bgwf_pkg::PH_IDLE;
                awaiting_nxt  = 1'b1;
              end
              bgwf_pkg::PH_IDLE: begin
                idle_done_nxt = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      bgwf_pkg::FUNC_DATA: begin
        if (awaiting_r) begin
          awaiting_nxt = 1'b0;
          unique case (phase_r)
            bgwf_pkg::PH_LOW:  tile_id_nxt = in_mem_data;
            bgwf_pkg::PH_HIGH: begin
              low_nxt  = in_mem_data;
              full_nxt = 1'b1;
            end
            bgwf_pkg::PH_IDLE: high_nxt = in_mem_data;
            default: ;
          endcase
        end
      end
      bgwf_pkg::FUNC_TAKE: begin
        if (full_r) begin
          res.pixels_valid  = 1'b1;
          res.pixel_colors  = pix;
          res.pixel_palette = pal_r;
        end
        full_nxt      = 1'b0;
        low_nxt       = '0;
        high_nxt      = '0;
        pushed_nxt    = (pushed_r > bgwf_pkg::PUSH_LIMIT) ? bgwf_pkg::SWAP_NEVER
                                                          : pushed_r + 8'd8;
        phase_nxt     = bgwf_pkg::PH_ID;
        awaiting_nxt  = 1'b0;
        col_nxt       = col_r + 5'd1;
        idle_done_nxt = 1'b0;
      end
      default: ;
    endcase

    res.tile_staged = full_nxt && idle_done_nxt;
    res.fine_offset = win_off_nxt;
    res.line_mode   = mode_nxt;
  end

  // Fetch state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= bgwf_pkg::PH_ID;
      awaiting_r  <= 1'b0;
      hrc_r       <= '0;
      mode_r      <= bgwf_pkg::MODE_OFF;
      signed_r    <= 1'b0;
      bg_base_r   <= '0;
      win_base_r  <= '0;
      bg_row_r    <= '0;
      win_row_r   <= '0;
      col_r       <= '0;
      pushed_r    <= '0;
      swap_r      <= bgwf_pkg::SWAP_NEVER;
      swapped_r   <= 1'b0;
      idle_done_r <= 1'b0;
      tile_id_r   <= '0;
      data_addr_r <= '0;
      low_r       <= '0;
      high_r      <= '0;
      full_r      <= 1'b0;
      win_off_r   <= '0;
      pal_r       <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      awaiting_r  <= awaiting_nxt;
      hrc_r       <= hrc_nxt;
      mode_r      <= mode_nxt;
      signed_r    <= signed_nxt;
      bg_base_r   <= bg_base_nxt;
      win_base_r  <= win_base_nxt;
      bg_row_r    <= bg_row_nxt;
      win_row_r   <= win_row_nxt;
      col_r       <= col_nxt;
      pushed_r    <= pushed_nxt;
      swap_r      <= swap_nxt;
      swapped_r   <= swapped_nxt;
      idle_done_r <= idle_done_nxt;
      tile_id_r   <= tile_id_nxt;
      data_addr_r <= data_addr_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      full_r      <= full_nxt;
      win_off_r   <= win_off_nxt;
      pal_r       <= pal_nxt;
    end
  end

  bgwf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_beat)
  );

  assign out_read_req      = out_beat.read_req;
  assign out_read_addr     = out_beat.read_addr;
  assign out_tile_staged   = out_beat.tile_staged;
  assign out_pixels_valid  = out_beat.pixels_valid;
  assign out_pixel_colors  = out_beat.pixel_colors;
  assign out_pixel_palette = out_beat.pixel_palette;
  assign out_fine_offset   = out_beat.fine_offset;
  assign out_line_mode     = out_beat.line_mode;

endmodule

// ----- src/bgwf_line_setup.sv -----
`timescale 1ns / 1ps
// bgwf_line_setup: line-start geometry (mode, map row bases, rows, swap point).
// Depends on bgwf_pkg.

module bgwf_line_setup (
  input  logic [7:0]      lcd_control,
  input  logic [7:0]      window_x,
  input  logic [7:0]      window_y,
  input  logic [7:0]      scroll_x,
  input  logic [7:0]      scroll_y,
  input  logic [7:0]      line_number,
  output bgwf_pkg::setup_t setup
);

  logic [15:0] bg_map;
  logic [15:0] win_map;
  logic [7:0]  bg_y;
  logic [7:0]  win_y;
  logic        win_used;
  logic [7:0]  swap_calc;
  logic [7:0]  offs_calc;

  assign bg_map    = lcd_control[3] ? bgwf_pkg::MAP_HIGH_BASE : bgwf_pkg::MAP_LOW_BASE;
  assign win_map   = lcd_control[6] ? bgwf_pkg::MAP_HIGH_BASE : bgwf_pkg::MAP_LOW_BASE;
  assign bg_y      = scroll_y + line_number;
  assign win_y     = line_number - window_y;
  assign swap_calc = window_x - bgwf_pkg::WX_ALIGNED;
  assign offs_calc = bgwf_pkg::WX_ALIGNED - window_x;
  assign win_used  = lcd_control[5] && (window_x <= bgwf_pkg::WX_MAX) &&
                     (window_y <= bgwf_pkg::WY_MAX) && (window_y <= line_number);

  // Mode pick, then per-layer row geometry
  always_comb begin
    setup             = '0;
    setup.signed_data = ~lcd_control[4];
    setup.swap_point  = bgwf_pkg::SWAP_NEVER;
    if (!lcd_control[0]) begin
      setup.mode     = bgwf_pkg::MODE_OFF;
      setup.bg_base  = bgwf_pkg::OFF_ADDR;
      setup.win_base = bgwf_pkg::OFF_ADDR;
    end else begin
      priority if (!win_used) begin
        setup.mode = bgwf_pkg::MODE_BG;
      end else if (window_x == 8'd0 || window_x == bgwf_pkg::WX_MAX) begin
        setup.mode       = bgwf_pkg::MODE_WIN;
        setup.win_offset = bgwf_pkg::FULL_OFFSET;
      end else if (window_x < bgwf_pkg::WX_ALIGNED) begin
        setup.mode       = bgwf_pkg::MODE_WIN;
        setup.win_offset = offs_calc[3:0];
      end else if (window_x == bgwf_pkg::WX_ALIGNED) begin
        setup.mode = bgwf_pkg::MODE_WIN;
      end else begin
        setup.mode       = bgwf_pkg::MODE_BG_WIN;
        setup.swap_point = swap_calc;
      end
      // background layer
      if (setup.mode == bgwf_pkg::MODE_BG || setup.mode == bgwf_pkg::MODE_BG_WIN) begin
        setup.tile_col = scroll_x[7:3];
        setup.bg_row   = bg_y[2:0];
        setup.bg_base  = bg_map + {6'd0, bg_y[7:3], 5'd0};
      end
      // window layer
      if (setup.mode == bgwf_pkg::MODE_WIN || setup.mode == bgwf_pkg::MODE_BG_WIN) begin
        setup.win_row  = win_y[2:0];
        setup.win_base = win_map + {6'd0, win_y[7:3], 5'd0};
      end
    end
  end

endmodule

// ----- src/bgwf_out_buf.sv -----
`timescale 1ns / 1ps
// bgwf_out_buf: two-entry result buffer (output register plus skid entry).
// Depends on bgwf_pkg.

module bgwf_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bgwf_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output bgwf_pkg::result_t out_data
);

  logic              main_valid_r;
  logic              skid_valid_r;
  bgwf_pkg::result_t main_r;
  bgwf_pkg::result_t skid_r;
  logic              pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !main_valid_r) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (pop || !main_valid_r) begin
      main_r <= skid_valid_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

// ----- src/bgwf_checker.sv -----
`timescale 1ns / 1ps
// bgwf_checker: port-level checks of the tile fetcher result channel.
// Depends on bgwf_pkg and bg_window_tile_fetcher_unit, to which it is bound below.

module bgwf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_read_req,
  input logic [15:0] out_read_addr,
  input logic        out_pixels_valid,
  input logic [15:0] out_pixel_colors,
  input logic [7:0]  out_pixel_palette,
  input logic [3:0]  out_fine_offset,
  input logic [1:0]  out_line_mode
);

  // A stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_addr) && $stable(out_pixel_colors))
    else $error("result beat changed under stall");

  // No address without a request
  a_addr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_req |-> out_read_addr == 16'd0)
    else $error("read address set without request");

  // Pixels and palette are zero unless handed out
  a_pix_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixels_valid |-> out_pixel_colors == 16'd0 && out_pixel_palette == 8'd0)
    else $error("pixel data set without valid pixels");

  // Window offset only in window-only mode, never above a tile
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fine_offset <= 4'd8 &&
                  (out_line_mode == bgwf_pkg::MODE_WIN || out_fine_offset == 4'd0))
    else $error("window offset out of place");

endmodule

bind bg_window_tile_fetcher_unit bgwf_checker u_bgwf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_read_req      (out_read_req),
  .out_read_addr     (out_read_addr),
  .out_pixels_valid  (out_pixels_valid),
  .out_pixel_colors  (out_pixel_colors),
  .out_pixel_palette (out_pixel_palette),
  .out_fine_offset   (out_fine_offset),
  .out_line_mode     (out_line_mode)
);
